// ===== rtl/tsfs_pkg.sv =====
// Shared types, register indexes and constants of the touch sample filter and scale block.
package tsfs_pkg;

  // Converter sample width and configuration register width.
  localparam int SAMPLE_BITS = 12;
  localparam int REG_BITS    = 12;

  // Defaults for the top-level parameters.
  localparam int MAX_BURST_DEF   = 9;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Channel codes carried in the kind field.
  localparam logic [1:0] KIND_PRESSURE = 2'd0;
  localparam logic [1:0] KIND_X        = 2'd1;
  localparam logic [1:0] KIND_Y        = 2'd2;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRESSURE_MIN  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_X_RAW_HIGH    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_X_RAW_LOW     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Y_RAW_HIGH    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_Y_RAW_LOW     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 3'd6;

  // Register reset values.
  localparam logic [REG_BITS-1:0] RST_PRESSURE_MIN  = 12'd50;
  localparam logic [REG_BITS-1:0] RST_X_RAW_HIGH    = 12'd3850;
  localparam logic [REG_BITS-1:0] RST_X_RAW_LOW     = 12'd230;
  localparam logic [REG_BITS-1:0] RST_Y_RAW_HIGH    = 12'd3620;
  localparam logic [REG_BITS-1:0] RST_Y_RAW_LOW     = 12'd330;
  localparam logic [REG_BITS-1:0] RST_SCREEN_WIDTH  = 12'd480;
  localparam logic [REG_BITS-1:0] RST_SCREEN_HEIGHT = 12'd272;

  // One converter sample request.
  typedef struct packed {
    logic [1:0]             kind;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } in_item_t;

  // One touch report.
  typedef struct packed {
    logic                touched;
    logic [REG_BITS-1:0] x_pos;
    logic [REG_BITS-1:0] y_pos;
  } out_item_t;

  // Calibration registers as seen by the back end.
  typedef struct packed {
    logic [REG_BITS-1:0] pressure_min;
    logic [REG_BITS-1:0] x_raw_high;
    logic [REG_BITS-1:0] x_raw_low;
    logic [REG_BITS-1:0] y_raw_high;
    logic [REG_BITS-1:0] y_raw_low;
    logic [REG_BITS-1:0] screen_width;
    logic [REG_BITS-1:0] screen_height;
  } cfg_t;

endpackage

// ===== rtl/touch_sample_filter_and_scale.sv =====
// Flow: a touch report is issued after the mean division, scaling multiply and scaling
// division of its Y burst; a no-touch report after the mean division of its pressure burst.
// Throughput: one sample per cycle inside a burst while the job queue is not full; the
// back end's bit-serial divider runs once per pressure job or ignored axis burst and twice per
// calibrated axis, and a two-entry job queue lets the front keep taking samples meanwhile.
// Reset: synchronous rst restores register defaults and clears the accumulators,
// the queue, the pressure flag, the held X coordinate and the output valid flag.
module touch_sample_filter_and_scale #(
  parameter int MAX_BURST   = tsfs_pkg::MAX_BURST_DEF,
  parameter int QUEUE_DEPTH = tsfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  input  tsfs_pkg::in_item_t                    sample_data,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output tsfs_pkg::out_item_t                   result_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tsfs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [tsfs_pkg::REG_BITS-1:0]         cfg_data
);

  import tsfs_pkg::*;

  localparam int CNT_W     = $clog2(MAX_BURST + 1);
  localparam int SUM_W     = SAMPLE_BITS + CNT_W;
  localparam int DIV_NUM_W = (SUM_W > 2 * REG_BITS) ? SUM_W : 2 * REG_BITS;
  localparam int JOB_W     = 2 + SUM_W + CNT_W;

  cfg_t             cfg;
  logic             job_push;
  logic [1:0]       push_kind;
  logic [SUM_W-1:0] push_num;
  logic [CNT_W-1:0] push_cnt;
  logic             job_full;
  logic             job_pop;
  logic             job_valid;
  logic [JOB_W-1:0] job_word;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressure_min  <= RST_PRESSURE_MIN;
      cfg.x_raw_high    <= RST_X_RAW_HIGH;
      cfg.x_raw_low     <= RST_X_RAW_LOW;
      cfg.y_raw_high    <= RST_Y_RAW_HIGH;
      cfg.y_raw_low     <= RST_Y_RAW_LOW;
      cfg.screen_width  <= RST_SCREEN_WIDTH;
      cfg.screen_height <= RST_SCREEN_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PRESSURE_MIN:  cfg.pressure_min  <= cfg_data;
        CFG_X_RAW_HIGH:    cfg.x_raw_high    <= cfg_data;
        CFG_X_RAW_LOW:     cfg.x_raw_low     <= cfg_data;
        CFG_Y_RAW_HIGH:    cfg.y_raw_high    <= cfg_data;
        CFG_Y_RAW_LOW:     cfg.y_raw_low     <= cfg_data;
        CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tsfs_front #(
    .MAX_BURST (MAX_BURST),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_data  (sample_data),
    .job_push     (job_push),
    .job_kind     (push_kind),
    .job_num      (push_num),
    .job_cnt      (push_cnt),
    .job_full     (job_full)
  );

  tsfs_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data ({push_kind, push_num, push_cnt}),
    .full      (job_full),
    .pop       (job_pop),
    .nonempty  (job_valid),
    .pop_data  (job_word)
  );

  tsfs_back #(
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W),
    .DIV_NUM_W (DIV_NUM_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job_valid    (job_valid),
    .job_pop      (job_pop),
    .job_kind     (job_word[JOB_W-1 -: 2]),
    .job_num      (job_word[CNT_W +: SUM_W]),
    .job_cnt      (job_word[CNT_W-1:0]),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

endmodule

// ===== rtl/tsfs_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module tsfs_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift the next numerator bit into the partial remainder and test it.
  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  // Step counter; done pulses for one cycle after the final step.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      if (start) begin
        cnt <= CNT_W'(NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
      done <= !start && (cnt == CNT_W'(1));
    end
  end

  // Datapath: quotient bits enter at the bottom as numerator bits leave the top.
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      divisor <= den;
      quot    <= num;
    end else if (cnt != '0) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/tsfs_queue.sv =====
// Small first-in first-out queue of burst jobs between front and back end.
module tsfs_queue #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = fill == CNT_W'(DEPTH);
  assign nonempty = fill != '0;
  assign pop_data = slots[rd_ptr];

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/tsfs_front.sv =====
// Front end: accumulates burst sum, minimum, maximum and count and queues one job per burst.
module tsfs_front #(
  parameter int MAX_BURST = tsfs_pkg::MAX_BURST_DEF,
  parameter int CNT_W     = 4,
  parameter int SUM_W     = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  tsfs_pkg::in_item_t     sample_data,
  output logic                   job_push,
  output logic [1:0]             job_kind,
  output logic [SUM_W-1:0]       job_num,
  output logic [CNT_W-1:0]       job_cnt,
  input  logic                   job_full
);

  import tsfs_pkg::*;

  logic [SUM_W-1:0]       burst_sum;
  logic [SAMPLE_BITS-1:0] burst_min;
  logic [SAMPLE_BITS-1:0] burst_max;
  logic [CNT_W-1:0]       burst_count;

  logic                   accept;
  logic                   use_item;
  logic                   room;
  logic [SUM_W-1:0]       sum_next;
  logic [SAMPLE_BITS-1:0] min_next;
  logic [SAMPLE_BITS-1:0] max_next;
  logic [CNT_W-1:0]       count_next;

  assign sample_ready = !job_full;
  assign accept       = sample_valid && sample_ready;
  assign use_item     = accept && (sample_data.kind != KIND_UNUSED);
  assign room         = burst_count < CNT_W'(MAX_BURST);

  // Fold the current sample into the running statistics while the burst holds fewer than MAX_BURST samples.
  always_comb begin
    sum_next   = burst_sum;
    min_next   = burst_min;
    max_next   = burst_max;
    count_next = burst_count;
    if (room) begin
      sum_next   = burst_sum + SUM_W'(sample_data.sample);
      min_next   = (sample_data.sample < burst_min) ? sample_data.sample : burst_min;
      max_next   = (sample_data.sample > burst_max) ? sample_data.sample : burst_max;
      count_next = burst_count + CNT_W'(1);
    end
  end

  // Job for the back end: trimmed sum and divisor, or plain sum for short bursts.
  always_comb begin
    job_push = use_item && sample_data.last;
    job_kind = sample_data.kind;
    if (count_next > CNT_W'(2)) begin
      job_num = sum_next - SUM_W'(min_next) - SUM_W'(max_next);
      job_cnt = count_next - CNT_W'(2);
    end else begin
      job_num = sum_next;
      job_cnt = count_next;
    end
  end

  // Accumulators restart after every marked sample that is not of the unused kind.
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_sum   <= '0;
      burst_min   <= '1;
      burst_max   <= '0;
      burst_count <= '0;
    end else if (use_item) begin
      if (sample_data.last) begin
        burst_sum   <= '0;
        burst_min   <= '1;
        burst_max   <= '0;
        burst_count <= '0;
      end else begin
        burst_sum   <= sum_next;
        burst_min   <= min_next;
        burst_max   <= max_next;
        burst_count <= count_next;
      end
    end
  end

endmodule

// ===== rtl/tsfs_back.sv =====
// Back end: divides each burst, qualifies pressure, calibrates X and Y and issues reports.
module tsfs_back #(
  parameter int CNT_W     = 4,
  parameter int SUM_W     = 16,
  parameter int DIV_NUM_W = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  tsfs_pkg::cfg_t      cfg,
  input  logic                job_valid,
  output logic                job_pop,
  input  logic [1:0]          job_kind,
  input  logic [SUM_W-1:0]    job_num,
  input  logic [CNT_W-1:0]    job_cnt,
  output logic                result_valid,
  input  logic                result_ready,
  output tsfs_pkg::out_item_t result_data
);

  import tsfs_pkg::*;

  localparam int PROD_W = 2 * REG_BITS;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DIV1   = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_DSTART = 7'b0001000,
    S_DIV2   = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t                 state;
  logic [1:0]             kind;
  logic                   pressure_ok;
  logic [REG_BITS-1:0]    held_x;
  logic [REG_BITS-1:0]    v_c;
  logic [REG_BITS-1:0]    sel_lo;
  logic [REG_BITS-1:0]    sel_size;
  logic [REG_BITS-1:0]    span;
  logic [REG_BITS-1:0]    coord;
  logic [PROD_W-1:0]      prod;
  out_item_t              res_hold;

  logic                   div_start;
  logic [DIV_NUM_W-1:0]   div_num;
  logic [REG_BITS-1:0]    div_den;
  logic                   div_done;
  logic [DIV_NUM_W-1:0]   div_quot;

  logic [SAMPLE_BITS-1:0] burst_val;
  logic [REG_BITS-1:0]    axis_hi;
  logic [REG_BITS-1:0]    axis_lo;
  logic [REG_BITS-1:0]    axis_size;
  logic [REG_BITS-1:0]    v_top;
  logic                   out_free;

  // The shared divider serves the burst mean and then the axis scaling.
  assign job_pop   = (state == S_IDLE) && job_valid;
  assign div_start = job_pop || (state == S_DSTART);
  assign div_num   = (state == S_IDLE) ? DIV_NUM_W'(job_num) : DIV_NUM_W'(prod);
  assign div_den   = (state == S_IDLE) ? REG_BITS'(job_cnt) : span;

  tsfs_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (REG_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Axis selection and clamping of the burst value.
  always_comb begin
    burst_val = div_quot[SAMPLE_BITS-1:0];
    if (kind == KIND_X) begin
      axis_hi   = cfg.x_raw_high;
      axis_lo   = cfg.x_raw_low;
      axis_size = cfg.screen_width;
    end else begin
      axis_hi   = cfg.y_raw_high;
      axis_lo   = cfg.y_raw_low;
      axis_size = cfg.screen_height;
    end
    v_top = (REG_BITS'(burst_val) > axis_hi) ? axis_hi : REG_BITS'(burst_val);
  end

  assign out_free = !result_valid || result_ready;

  // Sequencer for one burst job at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      kind        <= KIND_PRESSURE;
      pressure_ok <= 1'b0;
      held_x      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            kind  <= job_kind;
            state <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_done) begin
            if (kind == KIND_PRESSURE) begin
              if (REG_BITS'(burst_val) > cfg.pressure_min) begin
                pressure_ok <= 1'b1;
                state       <= S_IDLE;
              end else begin
                pressure_ok <= 1'b0;
                res_hold    <= '0;
                state       <= S_OUT;
              end
            end else if (!pressure_ok || (kind == KIND_UNUSED)) begin
              state <= S_IDLE;
            end else if (axis_hi <= axis_lo) begin
              coord <= '0;
              state <= S_FIN;
            end else begin
              v_c      <= (v_top < axis_lo) ? axis_lo : v_top;
              sel_lo   <= axis_lo;
              sel_size <= axis_size;
              span     <= axis_hi - axis_lo;
              state    <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(sel_size) * PROD_W'(v_c - sel_lo);
          state <= S_DSTART;
        end
        S_DSTART: begin
          state <= S_DIV2;
        end
        S_DIV2: begin
          if (div_done) begin
            coord <= sel_size - div_quot[REG_BITS-1:0];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (kind == KIND_X) begin
            held_x <= coord;
            state  <= S_IDLE;
          end else begin
            res_hold.touched <= 1'b1;
            res_hold.x_pos   <= held_x;
            res_hold.y_pos   <= coord;
            pressure_ok      <= 1'b0;
            state            <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register holds a report until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      result_data <= res_hold;
    end
  end

endmodule
